// File: hw/rtl/rwh_pkg.sv
package rwh_pkg;

    // Default histogram depth and the random word's significant bits
    localparam int NUM_BINS_DEF = 302;
    localparam int RANDOM_BITS  = 31;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int WORD_W   = 31;
    localparam int SEL_W    = 9;
    localparam int KIND_W   = 2;
    localparam int POS_W    = 22;
    localparam int STEPS_W  = 21;
    localparam int SCALE_W  = 24;
    localparam int COUNT_W  = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 24;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 96;

    // Product of endpoint magnitude and scale, Q30.16 fraction
    localparam int PROD_W = POS_W + SCALE_W;
    localparam int FRAC_W = 16;

    // Step direction threshold: (2^RANDOM_BITS - 1) / 2
    localparam logic [WORD_W-1:0] RAND_MASK =
        WORD_W'((64'd1 << RANDOM_BITS) - 64'd1);
    localparam logic [WORD_W-1:0] RAND_HALF = RAND_MASK >> 1;

    localparam logic [STEPS_W-1:0] STEPS_RST = STEPS_W'(1);
    localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(3276800);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_STEP  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_WALK  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEPS = 1'd0,
        CFG_SCALE = 1'd1
    } t_cfg_idx;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
    endfunction

endpackage

// File: hw/rtl/random_walk_histogram_core.sv
// Channel   Dir  Handshake               Contents
// s_axis    in   i_s_tvalid/o_s_tready   tuser: operation; tdata: random_word, bin_select
// m_axis    out  o_m_tvalid/i_m_tready   tuser: result_kind; tdata: end_position,
//                                        bin_number, bin_count, total_count
// cfg       in   i_cfg_wr_en             i_cfg_index selects register, i_cfg_data value
//
// A step that does not end the walk only updates the position and step count. A step that ends the walk
// passes through accept, multiply, bin map, memory read and increment/write. A bin
// read passes through accept, memory read and result. A clear runs accept, a sweep that writes
// one histogram word per cycle through the single memory port, then the result.
// After reset the same sweep runs before o_s_tready rises.
// The block finishes a result only when the output register is empty or being
// drained, and waits in its final state while the output stalls.
module random_walk_histogram_core
    import rwh_pkg::*;
#(
    parameter int NUM_BINS = NUM_BINS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DAT_W-1:0]  i_cfg_data,
    // input stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // random_word[30:0], bin_select[39:31]
    input  logic [OP_W-1:0]       i_s_tuser,   // operation[1:0]
    // result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // end_position[21:0], bin_number[30:22],
                                               // bin_count[62:31], total_count[94:63]
    output logic [KIND_W-1:0]     o_m_tuser    // result_kind[1:0]
);

    localparam int BW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int SW = (BW > SEL_W) ? BW : SEL_W;
    localparam int QW = PROD_W - FRAC_W + 1;
    localparam int CENTER = 1 + (NUM_BINS - 2) / 2;
    localparam logic [BW-1:0] LAST_BIN   = BW'(NUM_BINS - 1);
    localparam logic [BW-1:0] CENTER_BIN = BW'(CENTER);
    localparam logic [QW-1:0] HIGH_SPAN  = QW'(NUM_BINS - 1 - CENTER);
    localparam logic [QW-1:0] LOW_SPAN   = QW'(CENTER);
    localparam logic [SW-1:0] LAST_SEL   = SW'(NUM_BINS - 1);

    typedef enum logic [8:0] {
        S_INIT    = 9'b000000001,  // clearing sweep after reset
        S_IDLE    = 9'b000000010,
        S_MUL     = 9'b000000100,
        S_BIN     = 9'b000001000,
        S_RD      = 9'b000010000,
        S_WR      = 9'b000100000,
        S_RDOUT   = 9'b001000000,
        S_CLR     = 9'b010000000,
        S_CLRDONE = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [STEPS_W-1:0] r_steps_per_walk;
    logic [SCALE_W-1:0] r_endpoint_scale;

    // walk state
    logic signed [POS_W-1:0] r_pos, n_pos;
    logic [STEPS_W-1:0]      r_steps, n_steps;
    logic [COUNT_W-1:0]      r_total, n_total;

    // datapath
    logic signed [POS_W-1:0] r_endp, n_endp;
    logic [PROD_W-1:0]       r_prod, n_prod;
    logic                    r_neg, n_neg;
    logic [BW-1:0]           r_addr, n_addr;
    logic                    r_is_read, n_is_read;

    // histogram memory
    logic [COUNT_W-1:0] r_hist [NUM_BINS];
    logic [COUNT_W-1:0] r_rdata;
    logic               mem_we;
    logic [COUNT_W-1:0] mem_wdata;

    // output register
    logic                  r_m_valid, n_m_valid;
    logic [KIND_W-1:0]     r_m_kind, n_m_kind;
    logic [POS_W-1:0]      r_m_endp, n_m_endp;
    logic [SEL_W-1:0]      r_m_bin, n_m_bin;
    logic [COUNT_W-1:0]    r_m_count, n_m_count;
    logic [COUNT_W-1:0]    r_m_total, n_m_total;

    // input fields
    t_op                   in_op;
    logic [WORD_W-1:0]     in_word;
    logic [SEL_W-1:0]      in_sel;
    logic [SW-1:0]         sel_ext;
    logic                  accept;
    logic                  push_ok;

    // step and bin mapping
    logic signed [POS_W-1:0] step_pos;
    logic [STEPS_W-1:0]      step_cnt;
    logic [POS_W-1:0]        endp_mag;
    logic [QW-1:0]           q_pos;
    logic [PROD_W:0]         prod_ceil;
    logic [QW-1:0]           q_neg;
    logic [BW-1:0]           bin_calc;
    logic [COUNT_W-1:0]      cnt_inc;

    assign in_op   = t_op'(i_s_tuser);
    assign in_word = i_s_tdata[WORD_W-1:0] & RAND_MASK;
    assign in_sel  = i_s_tdata[WORD_W +: SEL_W];
    assign sel_ext = SW'(in_sel);

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign push_ok    = !r_m_valid || i_m_tready;

    assign step_pos = (in_word < RAND_HALF) ? r_pos - POS_W'(1) : r_pos + POS_W'(1);
    assign step_cnt = r_steps + STEPS_W'(1);
    assign endp_mag = r_endp[POS_W-1] ? POS_W'(-r_endp) : POS_W'(r_endp);

    // floor toward minus infinity: ceil of the magnitude for negative endpoints
    assign q_pos     = QW'(r_prod >> FRAC_W);
    assign prod_ceil = {1'b0, r_prod} + (PROD_W+1)'((1 << FRAC_W) - 1);
    assign q_neg     = QW'(prod_ceil >> FRAC_W);

    assign cnt_inc = sat_inc(r_rdata);

    always_comb begin
        if (r_neg) begin
            bin_calc = (q_neg > LOW_SPAN) ? '0 : CENTER_BIN - BW'(q_neg);
        end else begin
            bin_calc = (q_pos > HIGH_SPAN) ? LAST_BIN : CENTER_BIN + BW'(q_pos);
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_steps   = r_steps;
        n_total   = r_total;
        n_endp    = r_endp;
        n_prod    = r_prod;
        n_neg     = r_neg;
        n_addr    = r_addr;
        n_is_read = r_is_read;
        mem_we    = 1'b0;
        mem_wdata = '0;
        n_m_valid = r_m_valid && !i_m_tready;
        n_m_kind  = r_m_kind;
        n_m_endp  = r_m_endp;
        n_m_bin   = r_m_bin;
        n_m_count = r_m_count;
        n_m_total = r_m_total;

        unique case (r_state) inside
            S_INIT, S_CLR: begin
                mem_we = 1'b1;
                if (r_addr == LAST_BIN) begin
                    n_state = (r_state == S_INIT) ? S_IDLE : S_CLRDONE;
                end else begin
                    n_addr = r_addr + BW'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (in_op)
                        OP_STEP: begin
                            if (step_cnt < r_steps_per_walk) begin
                                n_pos   = step_pos;
                                n_steps = step_cnt;
                            end else begin
                                n_endp    = step_pos;
                                n_pos     = '0;
                                n_steps   = '0;
                                n_is_read = 1'b0;
                                n_state   = S_MUL;
                            end
                        end
                        OP_READ: begin
                            n_addr    = (sel_ext > LAST_SEL) ? LAST_BIN : BW'(sel_ext);
                            n_is_read = 1'b1;
                            n_state   = S_RD;
                        end
                        OP_CLEAR: begin
                            n_total = '0;
                            n_addr  = '0;
                            n_state = S_CLR;
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL: begin
                n_prod  = PROD_W'(endp_mag) * PROD_W'(r_endpoint_scale);
                n_neg   = r_endp[POS_W-1];
                n_state = S_BIN;
            end
            S_BIN: begin
                n_addr  = bin_calc;
                n_state = S_RD;
            end
            S_RD: begin
                // read data lands in r_rdata at this edge
                n_state = r_is_read ? S_RDOUT : S_WR;
            end
            S_WR: begin
                if (push_ok) begin
                    mem_we    = 1'b1;
                    mem_wdata = cnt_inc;
                    n_total   = sat_inc(r_total);
                    n_m_valid = 1'b1;
                    n_m_kind  = KIND_WALK;
                    n_m_endp  = r_endp;
                    n_m_bin   = SEL_W'(r_addr);
                    n_m_count = cnt_inc;
                    n_m_total = sat_inc(r_total);
                    n_state   = S_IDLE;
                end
            end
            S_RDOUT: begin
                if (push_ok) begin
                    n_m_valid = 1'b1;
                    n_m_kind  = KIND_READ;
                    n_m_endp  = '0;
                    n_m_bin   = SEL_W'(r_addr);
                    n_m_count = r_rdata;
                    n_m_total = r_total;
                    n_state   = S_IDLE;
                end
            end
            S_CLRDONE: begin
                if (push_ok) begin
                    n_m_valid = 1'b1;
                    n_m_kind  = KIND_CLEAR;
                    n_m_endp  = '0;
                    n_m_bin   = '0;
                    n_m_count = '0;
                    n_m_total = '0;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_INIT;
            r_addr           <= '0;
            r_pos            <= '0;
            r_steps          <= '0;
            r_total          <= '0;
            r_is_read        <= 1'b0;
            r_m_valid        <= 1'b0;
            r_steps_per_walk <= STEPS_RST;
            r_endpoint_scale <= SCALE_RST;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_pos     <= n_pos;
            r_steps   <= n_steps;
            r_total   <= n_total;
            r_is_read <= n_is_read;
            r_m_valid <= n_m_valid;
            if (i_cfg_wr_en) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_STEPS: r_steps_per_walk <= i_cfg_data[STEPS_W-1:0];
                    CFG_SCALE: r_endpoint_scale <= i_cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_endp    <= n_endp;
        r_prod    <= n_prod;
        r_neg     <= n_neg;
        r_m_kind  <= n_m_kind;
        r_m_endp  <= n_m_endp;
        r_m_bin   <= n_m_bin;
        r_m_count <= n_m_count;
        r_m_total <= n_m_total;
    end

    // histogram memory, one port, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_hist[r_addr] <= mem_wdata;
        end
        r_rdata <= r_hist[r_addr];
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_m_kind;
    assign o_m_tdata  = {1'b0, r_m_total, r_m_count, r_m_bin, r_m_endp};

endmodule
